// ===== src/sacc_pkg.sv =====
package sacc_pkg;

  localparam int FIELD_W = 24;
  localparam int FUNC_W  = 2;
  localparam int IDF_W   = 8;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_COMPACT = 2'd2;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_NO_ID    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic REG_MEMORY_SIZE = 1'b0;
  localparam logic REG_FIT_POLICY  = 1'b1;

  localparam logic [23:0] MEM_RESET = 24'd524288;

  typedef struct packed {
    logic [1:0]  func;
    logic [23:0] request_size;
    logic [7:0]  segment_id;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] block_address;
    logic [23:0] free_total;
  } rsp_t;

endpackage

// ===== src/sacc_seg_mem.sv =====
module sacc_seg_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 57
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/segment_allocator_coalesce_compact_core.sv =====
// Alloc and free walk the table in passes (scan, shift up or copy down, free sum),
// each entry read through one table memory with registered read data.
// Compact and the unused code take fewer passes.
// Throughput: one command at a time; busy is high from acceptance until the result.
// Reset: synchronous rst; one free segment of the reset memory size, first fit.
// The receiver cannot stall the result strobe.
module segment_allocator_coalesce_compact_core
  import sacc_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_BITS    = 24,
  parameter int ID_BITS      = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  output logic        done,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);
  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = 2 * ADDR_BITS + 1 + ID_BITS;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] size;
    logic                 used;
    logic [ID_BITS-1:0]   id;
  } seg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_W, S_SCAN, S_DECIDE, S_SHIFT_W, S_SHIFT, S_PLACE, S_PLACE2,
    S_FREE_LW, S_FREE_L, S_REMOVE_W, S_REMOVE, S_COMPACT_W, S_COMPACT, S_SETTLE,
    S_SUM_W, S_SUM
  } state_t;

  state_t state;
  logic fit_policy;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;   // walk index
  logic [CW-1:0] pos;   // chosen / matched entry
  logic [CW-1:0] wr_n;  // compact write index
  logic [CW-1:0] rm_k;  // copy-down write index
  logic [1:0]    rm_left; // entries dropped by the merge
  logic found;
  logic [ADDR_BITS-1:0] best;
  logic [ADDR_BITS-1:0] acc_a, acc_b, total;
  logic [1:0] status;
  logic [ADDR_BITS-1:0] addr;
  cmd_t cur;
  seg_t prev_seg, hold_seg;

  // One table memory with a write port and a registered read port, driven by the sequencer.
  logic           we;
  logic [IW-1:0]  waddr, raddr;
  seg_t           wdata, rdata;
  logic [EW-1:0]  rdata_raw;

  sacc_seg_mem #(.DEPTH(MAX_SEGMENTS), .WIDTH(EW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );
  assign rdata = seg_t'(rdata_raw);

  logic [ADDR_BITS-1:0] req;
  logic [ID_BITS-1:0]   cur_id;
  assign req    = ADDR_BITS'(cur.request_size);
  assign cur_id = ID_BITS'(cur.segment_id);
  assign busy   = (state != S_IDLE);

  // Read address follows the walk pointer.
  always_comb begin
    raddr = ptr[IW-1:0];
  end

  // Free merge: right neighbour is in rdata, left neighbour was kept during the scan.
  logic                 rfree, lfree;
  logic [ADDR_BITS-1:0] merge_size;
  always_comb begin
    rfree      = (ptr < count) && !rdata.used;
    lfree      = (pos != '0) && !prev_seg.used;
    merge_size = hold_seg.size + (rfree ? rdata.size : '0);
    if (lfree) begin
      merge_size = merge_size + prev_seg.size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fit_policy  <= 1'b0;
      count       <= CW'(1);
      ptr         <= '0;
      done        <= 1'b0;
      we          <= 1'b1;
      waddr       <= '0;
      wdata       <= '{start: '0, size: ADDR_BITS'(MEM_RESET), used: 1'b0, id: '0};
    end else begin
      we   <= 1'b0;
      done <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_MEMORY_SIZE) begin
          count       <= CW'(1);
          we          <= 1'b1;
          waddr       <= '0;
          wdata       <= '{start: '0, size: ADDR_BITS'(cfg_data), used: 1'b0,
                           id: '0};
        end else begin
          fit_policy <= cfg_data[0];
        end
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cur    <= cmd;
            status <= ST_OK;
            addr   <= '0;
            found  <= 1'b0;
            best   <= '0;
            ptr    <= '0;
            wr_n   <= '0;
            acc_a  <= '0;
            acc_b  <= '0;
            total  <= '0;
            case (cmd.func)
              FUNC_ALLOC, FUNC_FREE: state <= S_SCAN_W;
              FUNC_COMPACT:          state <= S_COMPACT_W;
              default:               state <= S_SUM_W;
            endcase
          end
        end
        // Wait for registered read data.
        S_SCAN_W: state <= S_SCAN;
        S_SCAN: begin
          if (ptr >= count) begin
            state <= S_DECIDE;
          end else if (cur.func == FUNC_ALLOC) begin
            if (!rdata.used && rdata.size >= req) begin
              if (!found || (fit_policy && rdata.size > best)) begin
                found    <= 1'b1;
                best     <= rdata.size;
                pos      <= ptr;
                hold_seg <= rdata;
              end
              // First fit stops at the first segment that fits.
              if (!fit_policy) begin
                state <= S_DECIDE;
              end else begin
                ptr   <= ptr + CW'(1);
                state <= S_SCAN_W;
              end
            end else begin
              ptr   <= ptr + CW'(1);
              state <= S_SCAN_W;
            end
          end else begin
            if (rdata.used && rdata.id == cur_id) begin
              found    <= 1'b1;
              pos      <= ptr;
              hold_seg <= rdata;
              state    <= S_DECIDE;
            end else begin
              prev_seg <= rdata;
              ptr      <= ptr + CW'(1);
              state    <= S_SCAN_W;
            end
          end
        end
        S_DECIDE: begin
          if (!found) begin
            status <= (cur.func == FUNC_ALLOC) ? ST_NO_FIT : ST_NO_ID;
            ptr    <= '0;
            state  <= S_SUM_W;
          end else if (cur.func == FUNC_ALLOC) begin
            if (count >= CW'(MAX_SEGMENTS)) begin
              status <= ST_FULL;
              ptr    <= '0;
              state  <= S_SUM_W;
            end else begin
              ptr   <= count - CW'(1);
              state <= S_SHIFT_W;
            end
          end else begin
            // Read the right neighbour of the freed entry.
            ptr   <= pos + CW'(1);
            state <= S_FREE_LW;
          end
        end
        // Move entries up by one from the top down to pos+1.
        S_SHIFT_W: begin
          if (ptr <= pos) begin
            state <= S_PLACE;
          end else begin
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          we    <= 1'b1;
          waddr <= IW'(ptr + CW'(1));
          wdata <= rdata;
          ptr   <= ptr - CW'(1);
          state <= S_SHIFT_W;
        end
        // Shrink the chosen free segment, then place the block at its top end.
        S_PLACE: begin
          we    <= 1'b1;
          waddr <= pos[IW-1:0];
          wdata <= '{start: hold_seg.start, size: hold_seg.size - req, used: 1'b0,
                     id: hold_seg.id};
          addr  <= hold_seg.start + (hold_seg.size - req);
          state <= S_PLACE2;
        end
        S_PLACE2: begin
          we    <= 1'b1;
          waddr <= IW'(pos + CW'(1));
          wdata <= '{start: addr, size: req, used: 1'b1, id: cur_id};
          count <= count + CW'(1);
          state <= S_SETTLE;
        end
        // Free: write the merged entry and set up the copy-down.
        S_FREE_LW: state <= S_FREE_L;
        S_FREE_L: begin
          we  <= 1'b1;
          ptr <= pos + CW'(1) + CW'(rfree);
          if (lfree) begin
            waddr   <= IW'(pos - CW'(1));
            wdata   <= '{start: prev_seg.start, size: merge_size, used: 1'b0,
                         id: prev_seg.id};
            rm_k    <= pos;
            rm_left <= {1'b0, rfree} + 2'd1;
          end else begin
            waddr   <= pos[IW-1:0];
            wdata   <= '{start: hold_seg.start, size: merge_size, used: 1'b0,
                         id: hold_seg.id};
            rm_k    <= pos + CW'(1);
            rm_left <= {1'b0, rfree};
          end
          state <= S_REMOVE_W;
        end
        // Copy the remaining entries down over the merged ones.
        S_REMOVE_W: begin
          if (rm_left == 2'd0 || ptr >= count) begin
            count <= count - CW'(rm_left);
            state <= S_SETTLE;
          end else begin
            state <= S_REMOVE;
          end
        end
        S_REMOVE: begin
          we    <= 1'b1;
          waddr <= rm_k[IW-1:0];
          wdata <= rdata;
          rm_k  <= rm_k + CW'(1);
          ptr   <= ptr + CW'(1);
          state <= S_REMOVE_W;
        end
        // Compact: pack used entries from address zero, gather free space.
        S_COMPACT_W: state <= S_COMPACT;
        S_COMPACT: begin
          if (ptr >= count) begin
            if (wr_n < CW'(MAX_SEGMENTS)) begin
              we    <= 1'b1;
              waddr <= wr_n[IW-1:0];
              wdata <= '{start: acc_a, size: acc_b, used: 1'b0, id: '0};
              count <= wr_n + CW'(1);
            end else begin
              count <= wr_n;
            end
            state <= S_SETTLE;
          end else begin
            if (rdata.used) begin
              we    <= 1'b1;
              waddr <= wr_n[IW-1:0];
              wdata <= '{start: acc_a, size: rdata.size, used: 1'b1, id: rdata.id};
              acc_a <= acc_a + rdata.size;
              wr_n  <= wr_n + CW'(1);
            end else begin
              acc_b <= acc_b + rdata.size;
            end
            ptr   <= ptr + CW'(1);
            state <= S_COMPACT_W;
          end
        end
        // Let the last table write land before the free sum reads it.
        S_SETTLE: begin
          ptr   <= '0;
          state <= S_SUM_W;
        end
        S_SUM_W: state <= S_SUM;
        S_SUM: begin
          if (ptr >= count) begin
            done  <= 1'b1;
            rsp   <= '{status: status, block_address: 24'(addr), free_total: 24'(total)};
            state <= S_IDLE;
          end else begin
            if (!rdata.used) begin
              total <= total + rdata.size;
            end
            ptr   <= ptr + CW'(1);
            state <= S_SUM_W;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy);
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy);
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CW'(MAX_SEGMENTS)));
endmodule
